@@ hdl/assert_macros.svh @@
// Assertion macros for the top-level RTL file of the BCD byte converter.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/b2bcd_pkg.sv @@
// Package for the binary to packed BCD byte converter.
// Holds widths, the BCD word type and the status structs; depends on nothing.
`default_nettype none

package b2bcd_pkg;

	localparam int BIN_W   = 32;
	localparam int DIGIT_W = 4;
	localparam int DIGITS  = 10;
	localparam int BYTE_W  = 8;
	localparam int NBYTES  = 5;
	localparam int BCD_W   = DIGITS * DIGIT_W;
	localparam int IDX_W   = $clog2(NBYTES);
	localparam int STEP_W  = $clog2(BIN_W);

	// Digits of five or more are corrected by three before each shift.
	localparam logic [DIGIT_W-1:0] ADJ_MIN = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] ADJ_ADD = DIGIT_W'(3);
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

	typedef logic [NBYTES-1:0][BYTE_W-1:0] bcd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_stat_t;

	typedef struct packed {
		logic busy;
		logic finish;
	} emit_stat_t;

endpackage

`default_nettype wire

@@ hdl/b2bcd_if.sv @@
// Handshake channels of the BCD byte converter: binary input and BCD byte output.
// Depends on b2bcd_pkg for the payload widths.
`default_nettype none

interface b2bcd_bin_if import b2bcd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] binary_value;

	modport source (output valid, output binary_value, input ready);
	modport sink   (input valid, input binary_value, output ready);
endinterface

interface b2bcd_byte_if import b2bcd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] bcd_byte;
	logic              last_byte;

	modport source (output valid, output bcd_byte, output last_byte, input ready);
	modport sink   (input valid, input bcd_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/b2bcd_dabble.sv @@
// Shift-and-add-three converter: one input bit per cycle into a ten digit BCD word.
// Depends on b2bcd_pkg.
`default_nettype none

module b2bcd_dabble import b2bcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BIN_W-1:0] bin_val,
	output bcd_t             bcd,
	output conv_stat_t       stat
);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BIN_W - 1);

	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  adj;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	// Every digit is corrected on its own lane, then the whole word shifts once.
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] >= ADJ_MIN) begin
				adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W] + ADJ_ADD;
			end else begin
				adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin_val;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end
	end

	assign bcd       = bcd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

@@ hdl/b2bcd_emit.sv @@
// Byte emitter: finds the highest non-zero digit pair and sends pairs down to the lowest.
// Depends on b2bcd_pkg and the b2bcd_byte_if channel.
`default_nettype none

module b2bcd_emit import b2bcd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  bcd_t            bcd,
	b2bcd_byte_if.source    bcd_out,
	output emit_stat_t      stat
);

	bcd_t              bcd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_dn;
	logic [IDX_W-1:0]  top_idx;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              valid_q;
	logic              xfer;

	// Highest non-zero pair; a value of zero still gives the lowest pair.
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < NBYTES; i++) begin
			if (bcd[i] != '0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign idx_dn = idx_q - IDX_W'(1);
	assign xfer   = valid_q && bcd_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= top_idx;
		end else if (xfer) begin
			if (last_q) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_dn;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q  <= bcd;
			byte_q <= bcd[top_idx];
			last_q <= (top_idx == '0);
		end else if (xfer && !last_q) begin
			byte_q <= bcd_q[idx_dn];
			last_q <= (idx_dn == '0);
		end
	end

	assign bcd_out.valid     = valid_q;
	assign bcd_out.bcd_byte  = byte_q;
	assign bcd_out.last_byte = last_q;
	assign stat.busy         = valid_q;
	assign stat.finish       = xfer && last_q;

endmodule

`default_nettype wire

@@ hdl/binary_to_packed_bcd_bytes.sv @@
// Binary to packed BCD bytes: a 32-bit value in, one to five BCD bytes out, MSB first.
// The shift-add-3 unit takes one input bit per cycle; its done strobe loads the emitter,
// which sends one byte per cycle while the output is ready. A new value is accepted
// only when the sequencer is idle again, after the last byte of the previous one.
// arst_n clears the sequencer and all valid flags; data registers are not reset.
// Depends on b2bcd_pkg, b2bcd_if, b2bcd_dabble, b2bcd_emit and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module binary_to_packed_bcd_bytes import b2bcd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	b2bcd_bin_if.sink     bin,
	b2bcd_byte_if.source  bcd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic       start;
	bcd_t       conv_bcd;
	conv_stat_t conv_stat;
	emit_stat_t emit_stat;

	assign bin.ready = (state_q == ST_IDLE);
	assign start     = bin.valid && bin.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (conv_stat.done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_stat.finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	b2bcd_dabble u_dabble (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.bin_val (bin.binary_value),
		.bcd     (conv_bcd),
		.stat    (conv_stat)
	);

	b2bcd_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (conv_stat.done),
		.bcd     (conv_bcd),
		.bcd_out (bcd),
		.stat    (emit_stat)
	);

	// A transfer in must start the converter straight away.
	`ASSERT_NEXT(a_start_conv, start, conv_stat.busy && state_q == ST_CONV, "converter not started")
	// The converter only finishes while the sequencer waits for it.
	`ASSERT_SAME(a_done_in_conv, conv_stat.done, state_q == ST_CONV && !emit_stat.busy, "conversion done out of sequence")
	// Bytes are only offered in the emit phase, never alongside a new input.
	`ASSERT_SAME(a_emit_phase, bcd.valid, state_q == ST_EMIT && !bin.ready, "byte offered outside emit phase")
	// Both nibbles of every offered byte are decimal digits.
	`ASSERT_SAME(a_digits_ok, bcd.valid, bcd.bcd_byte[3:0] <= DIGIT_MAX && bcd.bcd_byte[7:4] <= DIGIT_MAX, "nibble is not a decimal digit")

endmodule

`default_nettype wire

@@ tb/binary_to_packed_bcd_bytes_tb.sv @@
// Self-checking testbench for the binary to packed BCD byte converter.
// Drives 32-bit values over the binary channel and checks every BCD byte transfer.
// Depends on b2bcd_pkg, b2bcd_if and binary_to_packed_bcd_bytes.
`timescale 1ns / 100ps

module binary_to_packed_bcd_bytes_tb;
	import b2bcd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int IDLE_PERCENT = 22;

	typedef struct {
		logic [BYTE_W-1:0] bcd_byte;
		logic              last_byte;
	} bcd_byte_t;

	logic clk;
	logic arst_n;
	logic quiet_mode;
	int   error_count;
	int   cycle_count;

	bcd_byte_t expected_bytes[$];

	b2bcd_bin_if  bin_ch ();
	b2bcd_byte_if bcd_ch ();

	binary_to_packed_bcd_bytes DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bin    (bin_ch),
		.bcd    (bcd_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Splits a value into decimal digit pairs and queues them most significant first.
	task automatic queue_bcd_bytes(input logic [BIN_W-1:0] value);
		logic [BIN_W-1:0]  rest;
		logic [BIN_W-1:0]  lo;
		logic [BIN_W-1:0]  hi;
		logic [BYTE_W-1:0] pairs[NBYTES];
		int                count;
		bcd_byte_t         entry;
		rest = value;
		count = 0;
		do begin
			lo = rest % 10;
			rest = rest / 10;
			hi = rest % 10;
			rest = rest / 10;
			pairs[count] = {hi[DIGIT_W-1:0], lo[DIGIT_W-1:0]};
			count++;
		end while (rest != 0 && count < NBYTES);
		for (int k = 0; k < count; k++) begin
			entry.bcd_byte = pairs[count - 1 - k];
			entry.last_byte = (k + 1 == count);
			expected_bytes.push_back(entry);
		end
	endtask

	// Called at a rising edge; returns at the edge on which the value was transferred.
	task automatic send_value(input logic [BIN_W-1:0] value);
		while (!quiet_mode && $urandom_range(99) < IDLE_PERCENT) begin
			bin_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bin_ch.valid <= 1'b1;
		bin_ch.binary_value <= value;
		@(posedge clk);
		while (!bin_ch.ready)
			@(posedge clk);
		queue_bcd_bytes(value);
	endtask

	// Picks a value of a random decimal length, so that every byte count is common.
	function automatic logic [BIN_W-1:0] value_of_random_length();
		longint unsigned lo;
		longint unsigned hi;
		int              digits;
		digits = $urandom_range(1, DIGITS);
		lo = (digits == 1) ? 0 : 64'd1;
		for (int d = 1; d < digits; d++)
			lo = lo * 10;
		hi = 64'd1;
		for (int d = 0; d < digits; d++)
			hi = hi * 10;
		hi = hi - 1;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		return BIN_W'(lo + (longint'($urandom) % (hi - lo + 1)));
	endfunction

	task automatic test_digit_boundaries();
		logic [BIN_W-1:0] values[$];
		values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
			32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
			32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999,
			32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555,
			32'hAAAA_AAAA, 32'd1234567890};
		foreach (values[i])
			send_value(values[i]);
	endtask

	task automatic test_random_values(input int count);
		logic [BIN_W-1:0] value;
		longint unsigned  power;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					value = $urandom;
				end
				3: begin
					// Values next to a power of ten change the digit count.
					power = 64'd1;
					repeat ($urandom_range(1, DIGITS - 1))
						power = power * 10;
					value = BIN_W'(power + $urandom_range(2) - 1);
				end
				default: begin
					value = value_of_random_length();
				end
			endcase
			send_value(value);
		end
	endtask

	task automatic test_back_to_back(input int count);
		quiet_mode <= 1'b1;
		test_random_values(count);
		quiet_mode <= 1'b0;
	endtask

	// Output side: random back-pressure, none while quiet_mode is set.
	initial begin
		bcd_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			bcd_ch.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		bcd_byte_t exp_byte;
		if (arst_n && bcd_ch.valid && bcd_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte transfer, expected none, got %02h last %0b",
					$time, bcd_ch.bcd_byte, bcd_ch.last_byte);
				error_count++;
			end else begin
				exp_byte = expected_bytes.pop_front();
				if (bcd_ch.bcd_byte !== exp_byte.bcd_byte) begin
					$display("%0t: bcd_byte expected %02h, got %02h",
						$time, exp_byte.bcd_byte, bcd_ch.bcd_byte);
					error_count++;
				end
				if (bcd_ch.last_byte !== exp_byte.last_byte) begin
					$display("%0t: last_byte expected %0b, got %0b",
						$time, exp_byte.last_byte, bcd_ch.last_byte);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		error_count = 0;
		quiet_mode = 1'b0;
		arst_n = 1'b0;
		bin_ch.valid = 1'b0;
		bin_ch.binary_value = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_digit_boundaries();
		test_random_values(200);
		test_back_to_back(60);
		test_random_values(145);

		bin_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		// Any stray byte after the last expected one is caught here.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/b2bcd_pkg.sv
hdl/b2bcd_if.sv
hdl/b2bcd_dabble.sv
hdl/b2bcd_emit.sv
hdl/binary_to_packed_bcd_bytes.sv
tb/binary_to_packed_bcd_bytes_tb.sv
